@@ hw/rtl/bbox_center_scale_normalize_defines.svh @@
// Assertion macros for the bounding-box normalizer.
`ifndef BBOX_CENTER_SCALE_NORMALIZE_DEFINES_SVH
`define BBOX_CENTER_SCALE_NORMALIZE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk_i with rst_ni low masking it.
`define BCSN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcsn same-cycle check failed");
// Next-cycle implication.
`define BCSN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcsn next-cycle check failed");
`else
`define BCSN_ASSERT_IMP(lbl, ante, cons)
`define BCSN_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/bcsn_pkg.sv @@
// Types and constants shared by the bounding-box normalizer.
`timescale 1ns / 1ps

package bcsn_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SCALE_WIDTH = 34;
  localparam int DIV_STEPS   = SCALE_WIDTH;

  localparam logic MODE_MEASURE   = 1'b0;
  localparam logic MODE_TRANSFORM = 1'b1;

  typedef struct packed {
    logic                          mode;
    logic                          first;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
  } bcsn_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] norm_x;
    logic signed [COORD_WIDTH-1:0] norm_y;
    logic signed [COORD_WIDTH-1:0] norm_z;
    logic                          degenerate;
  } bcsn_out_t;

  typedef struct packed {
    logic meas;
    logic meas_first;
    logic load_coord;
    logic load_mid;
    logic mag_en;
    logic pp_en;
    logic sum_en;
  } bcsn_lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAG,
    ST_PP,
    ST_SUM,
    ST_SAT
  } bcsn_state_e;

endpackage

@@ hw/rtl/bcsn_lane.sv @@
// One axis lane: bounds tracking, midpoint and the scaled, saturated offset.
`timescale 1ns / 1ps

module bcsn_lane import bcsn_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcsn_lane_ctrl_t               ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i,
  input  logic [SCALE_WIDTH-1:0]        scale_i,
  output logic [COORD_WIDTH-1:0]        extent_o,
  output logic signed [COORD_WIDTH-1:0] norm_o
);

  localparam int MagW  = COORD_WIDTH + 1;
  localparam int HalfW = SCALE_WIDTH / 2;
  localparam int HighW = SCALE_WIDTH - HalfW;
  localparam int LoW   = MagW + HalfW;
  localparam int HiW   = MagW + HighW;
  localparam int ProdW = MagW + SCALE_WIDTH;
  localparam int QW    = ProdW - FRAC_BITS;

  logic signed [COORD_WIDTH-1:0] min_q, max_q, mid_q, coord_q;
  logic [MagW-1:0]               mag_q;
  logic                          neg_q;
  logic [LoW-1:0]                p_lo_q;
  logic [HiW-1:0]                p_hi_q;
  logic [ProdW-1:0]              prod_q;

  logic [MagW-1:0]  span, mid_sum, diff;
  logic [QW-1:0]    q;
  logic [QW:0]      q_ceil;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      mid_q <= '0;
    end else begin
      if (ctrl_i.meas) begin
        if (ctrl_i.meas_first) begin
          min_q <= coord_i;
          max_q <= coord_i;
        end else begin
          if (coord_i < min_q) min_q <= coord_i;
          if (coord_i > max_q) max_q <= coord_i;
        end
      end
      if (ctrl_i.load_mid) begin
        mid_q <= mid_sum[MagW-1:1];
      end
    end
  end

  always_comb begin
    span     = {max_q[COORD_WIDTH-1], max_q} - {min_q[COORD_WIDTH-1], min_q};
    extent_o = span[MagW-1] ? '0 : span[COORD_WIDTH-1:0];
    // Dropping the low bit of the sign-extended sum rounds towards minus infinity.
    mid_sum  = {max_q[COORD_WIDTH-1], max_q} + {min_q[COORD_WIDTH-1], min_q};
    diff     = {coord_q[COORD_WIDTH-1], coord_q} - {mid_q[COORD_WIDTH-1], mid_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_coord) coord_q <= coord_i;
    if (ctrl_i.mag_en) begin
      neg_q <= diff[MagW-1];
      mag_q <= diff[MagW-1] ? ('0 - diff) : diff;
    end
    if (ctrl_i.pp_en) begin
      p_lo_q <= LoW'(mag_q) * LoW'(scale_i[HalfW-1:0]);
      p_hi_q <= HiW'(mag_q) * HiW'(scale_i[SCALE_WIDTH-1:HalfW]);
    end
    if (ctrl_i.sum_en) begin
      prod_q <= ProdW'(p_lo_q) + (ProdW'(p_hi_q) << HalfW);
    end
  end

  // A negative result is minus the ceiling of the magnitude quotient.
  always_comb begin
    q      = prod_q[ProdW-1:FRAC_BITS];
    q_ceil = {1'b0, q} + (QW + 1)'(|prod_q[FRAC_BITS-1:0]);
    if (!neg_q) begin
      if (|q[QW-1:COORD_WIDTH-1]) norm_o = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
      else                        norm_o = q[COORD_WIDTH-1:0];
    end else begin
      if (|q_ceil[QW:COORD_WIDTH-1]) norm_o = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
      else                           norm_o = '0 - q_ceil[COORD_WIDTH-1:0];
    end
  end

endmodule

@@ hw/rtl/bcsn_merge.sv @@
// Merging stage: largest extent over the lanes and the iterative scale divider.
`timescale 1ns / 1ps

module bcsn_merge import bcsn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COORD_WIDTH-1:0] ext_x_i,
  input  logic [COORD_WIDTH-1:0] ext_y_i,
  input  logic [COORD_WIDTH-1:0] ext_z_i,
  output logic [SCALE_WIDTH-1:0] scale_o,
  output logic                   degenerate_o,
  output logic                   busy_o
);

  localparam int CntW = $clog2(DIV_STEPS);

  logic [SCALE_WIDTH-1:0] scale_q;
  logic                   deg_q, busy_q;
  logic [COORD_WIDTH-1:0] divisor_q, rem_q;
  logic [CntW-1:0]        cnt_q;

  logic [COORD_WIDTH-1:0] ext_xy, ext_max;
  logic [COORD_WIDTH:0]   rem_sh, rem_sub;
  logic                   num_bit, fits;

  always_comb begin
    ext_xy  = (ext_y_i > ext_x_i) ? ext_y_i : ext_x_i;
    ext_max = (ext_z_i > ext_xy) ? ext_z_i : ext_xy;
    // The dividend is a single one in its top bit, so only the first step brings in a one.
    num_bit = (cnt_q == CntW'(DIV_STEPS - 1));
    rem_sh  = {rem_q, num_bit};
    rem_sub = rem_sh - {1'b0, divisor_q};
    fits    = (rem_sh >= {1'b0, divisor_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      deg_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else if (start_i) begin
      scale_q <= '0;
      deg_q   <= (ext_max == '0);
      busy_q  <= (ext_max != '0);
    end else if (busy_q) begin
      scale_q <= {scale_q[SCALE_WIDTH-2:0], fits};
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= ext_max;
      rem_q     <= '0;
      cnt_q     <= CntW'(DIV_STEPS - 1);
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[COORD_WIDTH-1:0] : rem_sh[COORD_WIDTH-1:0];
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign scale_o      = scale_q;
  assign degenerate_o = deg_q;
  assign busy_o       = busy_q;

endmodule

@@ hw/rtl/bbox_center_scale_normalize.sv @@
// Top level of the bounding-box normalizer: sequencer, lanes, merge and output register.
//
//   beat      direction  signals                               payload
//   input     in         in_valid_i / in_ready_o               bcsn_in_t
//   result    out        out_valid_o / out_ready_i             bcsn_out_t
//
// A measure beat gives no result.
// A transform beat steps through accept, magnitude, partial products, sum and saturate.
// The first transform beat of a pass also waits in the divide state for the bit-serial scale divider
// (one quotient bit a cycle), which does not run when the largest extent is zero.
// Reset clears bounds, midpoints and scale to zero; a full output register holds the
// saturate step until the waiting result beat is taken.
`timescale 1ns / 1ps
`include "bbox_center_scale_normalize_defines.svh"

module bbox_center_scale_normalize import bcsn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bcsn_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bcsn_out_t out_data_o
);

  bcsn_state_e state_q, state_d;
  bcsn_lane_ctrl_t lane_ctrl;

  logic in_accept, out_load, out_valid_q;
  bcsn_out_t out_data_q;

  logic [SCALE_WIDTH-1:0] scale;
  logic                   degenerate, merge_busy;
  logic [COORD_WIDTH-1:0] ext_x, ext_y, ext_z;
  logic signed [COORD_WIDTH-1:0] norm_x, norm_y, norm_z;
  logic                   out_norms_zero;

  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && in_data_i.mode == MODE_TRANSFORM) begin
          state_d = in_data_i.first ? ST_DIV : ST_MAG;
        end
      end
      ST_DIV: begin
        if (!merge_busy) state_d = ST_MAG;
      end
      ST_MAG: state_d = ST_PP;
      ST_PP:  state_d = ST_SUM;
      ST_SUM: state_d = ST_SAT;
      ST_SAT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o           = (state_q == ST_IDLE);
    out_load             = (state_q == ST_SAT) && (!out_valid_q || out_ready_i);
    lane_ctrl.meas       = in_accept && (in_data_i.mode == MODE_MEASURE);
    lane_ctrl.meas_first = in_data_i.first;
    lane_ctrl.load_coord = in_accept && (in_data_i.mode == MODE_TRANSFORM);
    lane_ctrl.load_mid   = in_accept && (in_data_i.mode == MODE_TRANSFORM) && in_data_i.first;
    lane_ctrl.mag_en     = (state_q == ST_MAG);
    lane_ctrl.pp_en      = (state_q == ST_PP);
    lane_ctrl.sum_en     = (state_q == ST_SUM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.norm_x     <= norm_x;
      out_data_q.norm_y     <= norm_y;
      out_data_q.norm_z     <= norm_z;
      out_data_q.degenerate <= degenerate;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bcsn_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .coord_i  (in_data_i.coord_x),
    .scale_i  (scale),
    .extent_o (ext_x),
    .norm_o   (norm_x)
  );

  bcsn_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .coord_i  (in_data_i.coord_y),
    .scale_i  (scale),
    .extent_o (ext_y),
    .norm_o   (norm_y)
  );

  bcsn_lane u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .coord_i  (in_data_i.coord_z),
    .scale_i  (scale),
    .extent_o (ext_z),
    .norm_o   (norm_z)
  );

  bcsn_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (lane_ctrl.load_mid),
    .ext_x_i      (ext_x),
    .ext_y_i      (ext_y),
    .ext_z_i      (ext_z),
    .scale_o      (scale),
    .degenerate_o (degenerate),
    .busy_o       (merge_busy)
  );

  assign out_norms_zero = (out_data_o.norm_x == '0) && (out_data_o.norm_y == '0) &&
                          (out_data_o.norm_z == '0);

  `BCSN_ASSERT_NXT(a_first_goes_div, lane_ctrl.load_mid, state_q == ST_DIV)
  `BCSN_ASSERT_IMP(a_busy_only_in_div, merge_busy, state_q == ST_DIV)
  `BCSN_ASSERT_NXT(a_sat_loads_output, out_load, out_valid_o)
  `BCSN_ASSERT_IMP(a_degenerate_zero, out_valid_o && out_data_o.degenerate, out_norms_zero)

endmodule
